// ----- hdl/dma_job_queue_channel_arbiter_macros.svh -----
// Assertion macros shared by the DMA job queue RTL.
`ifndef DMA_JOB_QUEUE_CHANNEL_ARBITER_MACROS_SVH
`define DMA_JOB_QUEUE_CHANNEL_ARBITER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DMAJQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dmajq assertion failed");
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DMAJQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dmajq assertion failed");
`else
`define DMAJQ_ASSERT_IMP(lbl, ante, cons)
`define DMAJQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/dmajq_pkg.sv -----
// Shared types, codes and helpers of the DMA job queue.
`timescale 1ns / 1ps
package dmajq_pkg;

  // Default sizes of the queue and of the channel set.
  localparam int unsigned DEF_QUEUE_DEPTH   = 8;
  localparam int unsigned DEF_CHANNEL_COUNT = 3;

  // Operation carried by an incoming transaction.
  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_DONE   = 1'b1
  } opcode_e;

  // Event code reported with each result.
  typedef enum logic [2:0] {
    EV_ACCEPTED   = 3'd0,
    EV_REJ_FULL   = 3'd1,
    EV_REJ_SIZE   = 3'd2,
    EV_DISPATCH   = 3'd3,
    EV_COMPLETION = 3'd4
  } event_e;

  // Transfer width code.
  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_e;

  // Control sequencer states.
  typedef enum logic {
    ST_IDLE     = 1'b0,
    ST_DISPATCH = 1'b1
  } state_e;

  // One queued job as it is held in the job memory.
  typedef struct packed {
    logic [31:0] dest_address;
    logic [31:0] source_address;
    logic [31:0] dest_step;
    logic [31:0] source_step;
    logic [31:0] element_count;
    size_e       size_code;
    logic [7:0]  tag;
  } job_t;

  // Maps a nonzero element size in bytes to its width code.
  function automatic size_e size_code_of(input logic [15:0] bytes);
    size_e code;
    case (bytes)
      16'd1:   code = SIZE_BYTE;
      16'd2:   code = SIZE_HALF;
      default: code = SIZE_WORD;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/dmajq_job_ram.sv -----
// Job memory: one write port and one registered read port.
`timescale 1ns / 1ps
module dmajq_job_ram #(
  parameter int unsigned DEPTH = dmajq_pkg::DEF_QUEUE_DEPTH,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  dmajq_pkg::job_t   wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output dmajq_pkg::job_t   rdata_o
);

  dmajq_pkg::job_t mem [DEPTH];
  dmajq_pkg::job_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dma_job_queue_channel_arbiter.sv -----
// Top level of the DMA job queue with first-free-channel dispatch.
//
//   Channel   Direction  Handshake            Transaction
//   command   in         start_i, busy_o      one submit or one completion
//   result    out        result_valid_o       one event report (last_o on the final one)
//
// A transaction is taken while busy_o is low; its first result appears in the next cycle.
// When a job can be dispatched, the sequencer then enters the dispatch state, which uses
// the job memory read, and busy_o is high while it is in that state.
// A completion for a channel that does not exist gives no result.
// Reset clears the pointers, the job count, the channel tags and frees every channel;
// the job memory is not cleared. Results cannot be stalled.
`timescale 1ns / 1ps
`include "dma_job_queue_channel_arbiter_macros.svh"
module dma_job_queue_channel_arbiter #(
  parameter int unsigned QUEUE_DEPTH   = dmajq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned CHANNEL_COUNT = dmajq_pkg::DEF_CHANNEL_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [31:0] dest_address_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_step_i,
  input  logic [31:0] source_step_i,
  input  logic [31:0] element_count_i,
  input  logic [15:0] element_bytes_i,
  input  logic [7:0]  callback_tag_i,
  input  logic [1:0]  done_channel_i,
  output logic        result_valid_o,
  output logic [2:0]  event_res_o,
  output logic [1:0]  channel_o,
  output logic [31:0] out_dest_address_o,
  output logic [31:0] out_source_address_o,
  output logic [31:0] out_dest_step_o,
  output logic [31:0] out_source_step_o,
  output logic [31:0] out_count_o,
  output logic [1:0]  size_code_o,
  output logic [7:0]  out_tag_o,
  output logic        last_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // Control state.
  dmajq_pkg::state_e      state_q, state_d;
  logic [PtrW-1:0]        wptr_q, wptr_d;
  logic [PtrW-1:0]        rptr_q, rptr_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CHANNEL_COUNT-1:0] free_q, free_d;
  logic [7:0]             tag_q [CHANNEL_COUNT];
  logic [7:0]             tag_d [CHANNEL_COUNT];
  logic                   fwd_q, fwd_d;

  // Result register.
  logic                   res_valid_q, res_valid_d;
  logic                   res_last_q, res_last_d;
  dmajq_pkg::event_e      res_ev_q, res_ev_d;
  logic [1:0]             res_ch_q, res_ch_d;
  dmajq_pkg::job_t        res_job_q, res_job_d;

  // Captured job of the accepted transaction, used for forwarding.
  dmajq_pkg::job_t        job_q;

  logic                   accept;
  logic                   ram_we;
  logic                   ram_re;
  logic                   go_disp;
  dmajq_pkg::job_t        job_in;
  dmajq_pkg::job_t        ram_rdata;
  dmajq_pkg::job_t        disp_job;
  logic                   is_submit;
  logic                   queue_full;
  logic                   bad_size;
  logic [CHANNEL_COUNT-1:0] done_hit;
  logic [7:0]             done_tag;
  logic [CHANNEL_COUNT-1:0] pick;
  logic [1:0]             pick_ch;

  assign accept = start_i && !busy_o;

  // Incoming job in its stored form.
  always_comb begin
    job_in.dest_address   = dest_address_i;
    job_in.source_address = source_address_i;
    job_in.dest_step      = dest_step_i;
    job_in.source_step    = source_step_i;
    job_in.element_count  = element_count_i;
    job_in.size_code      = dmajq_pkg::size_code_of(element_bytes_i);
    job_in.tag            = callback_tag_i;
  end

  // Request decode and completion lookup.
  always_comb begin
    is_submit  = (opcode_i == dmajq_pkg::OP_SUBMIT);
    queue_full = (count_q == CntW'(QUEUE_DEPTH));
    bad_size   = (element_bytes_i == 16'd0);
    done_tag   = 8'd0;
    for (int c = 0; c < int'(CHANNEL_COUNT); c++) begin
      done_hit[c] = (32'(done_channel_i) == c);
      if (done_hit[c]) begin
        done_tag = tag_q[c];
      end
    end
  end

  // Lowest free channel, as a one-hot vector and as a number.
  always_comb begin
    pick    = free_q & (~free_q + CHANNEL_COUNT'(1));
    pick_ch = 2'd0;
    for (int c = 0; c < int'(CHANNEL_COUNT); c++) begin
      if (pick[c]) begin
        pick_ch = 2'(c);
      end
    end
  end

  // The job just written bypasses the memory when it is also the one read.
  assign disp_job = fwd_q ? job_q : ram_rdata;

  dmajq_job_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (job_in),
    .re_i    (ram_re),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  // Queue, channel and result updates.
  always_comb begin
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    count_d     = count_q;
    free_d      = free_q;
    tag_d       = tag_q;
    fwd_d       = 1'b0;
    go_disp     = 1'b0;
    ram_we      = 1'b0;
    res_valid_d = 1'b0;
    res_last_d  = 1'b0;
    res_ev_d    = dmajq_pkg::EV_ACCEPTED;
    res_ch_d    = 2'd0;
    res_job_d   = '0;
    case (state_q)
      dmajq_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_submit) begin
            res_valid_d = 1'b1;
            if (queue_full) begin
              res_ev_d   = dmajq_pkg::EV_REJ_FULL;
              res_last_d = 1'b1;
            end else if (bad_size) begin
              res_ev_d   = dmajq_pkg::EV_REJ_SIZE;
              res_last_d = 1'b1;
            end else begin
              res_ev_d   = dmajq_pkg::EV_ACCEPTED;
              ram_we     = 1'b1;
              fwd_d      = (wptr_q == rptr_q);
              wptr_d     = (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
              count_d    = count_q + CntW'(1);
              go_disp    = (free_q != '0);
              res_last_d = !go_disp;
            end
          end else if (done_hit != '0) begin
            res_valid_d       = 1'b1;
            res_ev_d          = dmajq_pkg::EV_COMPLETION;
            res_ch_d          = done_channel_i;
            res_job_d.tag     = done_tag;
            free_d            = free_q | done_hit;
            go_disp           = (count_q != '0);
            res_last_d        = !go_disp;
          end
        end
      end
      dmajq_pkg::ST_DISPATCH: begin
        res_valid_d = 1'b1;
        res_last_d  = 1'b1;
        res_ev_d    = dmajq_pkg::EV_DISPATCH;
        res_ch_d    = pick_ch;
        res_job_d   = disp_job;
        free_d      = free_q & ~pick;
        for (int c = 0; c < int'(CHANNEL_COUNT); c++) begin
          if (pick[c]) begin
            tag_d[c] = disp_job.tag;
          end
        end
        rptr_d  = (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
        count_d = count_q - CntW'(1);
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dmajq_pkg::ST_IDLE: begin
        if (go_disp) begin
          state_d = dmajq_pkg::ST_DISPATCH;
        end
      end
      dmajq_pkg::ST_DISPATCH: begin
        state_d = dmajq_pkg::ST_IDLE;
      end
      default: begin
        state_d = dmajq_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs: busy while a dispatch is in progress; the head entry is read on accept.
  always_comb begin
    busy_o = 1'b0;
    ram_re = 1'b0;
    case (state_q)
      dmajq_pkg::ST_IDLE: begin
        ram_re = start_i;
      end
      dmajq_pkg::ST_DISPATCH: begin
        busy_o = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmajq_pkg::ST_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
      free_q      <= '1;
      fwd_q       <= 1'b0;
      res_valid_q <= 1'b0;
      for (int c = 0; c < int'(CHANNEL_COUNT); c++) begin
        tag_q[c] <= 8'd0;
      end
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      count_q     <= count_d;
      free_q      <= free_d;
      fwd_q       <= fwd_d;
      res_valid_q <= res_valid_d;
      tag_q       <= tag_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_last_q <= res_last_d;
    res_ev_q   <= res_ev_d;
    res_ch_q   <= res_ch_d;
    res_job_q  <= res_job_d;
    if (accept) begin
      job_q <= job_in;
    end
  end

  // Result ports.
  assign result_valid_o       = res_valid_q;
  assign event_res_o          = res_ev_q;
  assign channel_o            = res_ch_q;
  assign out_dest_address_o   = res_job_q.dest_address;
  assign out_source_address_o = res_job_q.source_address;
  assign out_dest_step_o      = res_job_q.dest_step;
  assign out_source_step_o    = res_job_q.source_step;
  assign out_count_o          = res_job_q.element_count;
  assign size_code_o          = res_job_q.size_code;
  assign out_tag_o            = res_job_q.tag;
  assign last_o               = res_last_q;

  // The job count never passes the queue depth.
  `DMAJQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CntW'(QUEUE_DEPTH))
  // A dispatch cycle always has a queued job and a free channel.
  `DMAJQ_ASSERT_IMP(a_disp_ready, state_q == dmajq_pkg::ST_DISPATCH,
                    (count_q != '0) && (free_q != '0))
  // A dispatch cycle is followed by a final dispatch result.
  `DMAJQ_ASSERT_NXT(a_disp_result, state_q == dmajq_pkg::ST_DISPATCH,
                    result_valid_o && last_o && (res_ev_q == dmajq_pkg::EV_DISPATCH))
  // While idle, a free channel and a waiting job never coexist.
  `DMAJQ_ASSERT_IMP(a_idle_settled, state_q == dmajq_pkg::ST_IDLE,
                    (count_q == '0) || (free_q == '0))
  // A result that is not the last one is followed by another result.
  `DMAJQ_ASSERT_NXT(a_more_follows, result_valid_o && !last_o, result_valid_o)

endmodule
